// ===== design/rvdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdq_pkg
// Shared types and constants for the reversible deque: store geometry,
// command and status codes, and the control bundle from the pointer unit.
// ----------------------------------------------------------------------------
package rvdq_pkg;

   localparam int DEPTH    = 1024;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_REVERSE    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-command decision from the pointer unit
   typedef struct packed {
      logic             wr_en;      // push lands in the store
      logic             rd_en;      // pop reads the store, data next cycle
      logic [IDX_W-1:0] addr;       // store entry touched by this command
      logic             rsp_now;    // immediate result (empty / full)
      status_type       rsp_status; // status of the immediate result
   } ctl_type;

endpackage

// ===== design/rvdq_if.sv =====
// ----------------------------------------------------------------------------
// rvdq_req_if / rvdq_rsp_if
// Valid/ready channels for deque commands and for pop / reject results.
// ----------------------------------------------------------------------------
interface rvdq_req_if
   import rvdq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DATA_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface rvdq_rsp_if
   import rvdq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output data_out, output status, input ready);
   modport sink   (input valid, input data_out, input status, output ready);
endinterface

// ===== design/rvdq_store.sv =====
// ----------------------------------------------------------------------------
// rvdq_store
// Single-port ring store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module rvdq_store
   import rvdq_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/rvdq_ptr.sv =====
// ----------------------------------------------------------------------------
// rvdq_ptr
// Head pointer, fill count and reverse flag. Maps each logical command onto
// a physical ring end, picks the store entry and updates on transfer.
// ----------------------------------------------------------------------------
module rvdq_ptr
   import rvdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [CMD_W-1:0] command,
   output ctl_type          ctl
);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;

   logic             full, empty, at_front;
   logic [IDX_W-1:0] head_dec, head_inc, back_idx;
   logic [CNT_W-1:0] back_off;
   logic [CNT_W:0]   back_sum;
   cmd_type          cmd;

   assign cmd   = cmd_type'(command);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // back slot: head + count for a push, head + count - 1 for a pop
   always_comb begin
      back_off = (cmd == CMD_POP_BACK || cmd == CMD_POP_FRONT) ? count_ff - 1'b1
                                                                : count_ff;
      back_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head_ff} + {1'b0, back_off};
      if (back_sum >= (CNT_W + 1)'(DEPTH)) begin
         back_sum = back_sum - (CNT_W + 1)'(DEPTH);
      end
      back_idx = back_sum[IDX_W-1:0];
   end

   always_comb begin
      at_front       = ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_POP_FRONT)) ^ rev_ff;
      ctl.wr_en      = 1'b0;
      ctl.rd_en      = 1'b0;
      ctl.addr       = back_idx;
      ctl.rsp_now    = 1'b0;
      ctl.rsp_status = ST_OK;
      head_in        = head_ff;
      count_in       = count_ff;
      rev_in         = rev_ff;
      case (cmd)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (full) begin
               ctl.rsp_now    = 1'b1;
               ctl.rsp_status = ST_FULL;
            end else begin
               ctl.wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               if (at_front) begin
                  ctl.addr = head_dec;
                  head_in  = head_dec;
               end
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (empty) begin
               ctl.rsp_now    = 1'b1;
               ctl.rsp_status = ST_EMPTY;
            end else begin
               ctl.rd_en = 1'b1;
               count_in  = count_ff - 1'b1;
               if (at_front) begin
                  ctl.addr = head_ff;
                  head_in  = head_inc;
               end
            end
         end
         CMD_REVERSE: begin
            rev_in = ~rev_ff;
         end
         default: begin
         end
      endcase
      if (!go) begin
         ctl.wr_en   = 1'b0;
         ctl.rd_en   = 1'b0;
         ctl.rsp_now = 1'b0;
         head_in     = head_ff;
         count_in    = count_ff;
         rev_in      = rev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

endmodule

// ===== design/reversible_deque.sv =====
// ----------------------------------------------------------------------------
// reversible_deque
// Double-ended queue of 32-bit words in a ring store with a reverse flag.
// ----------------------------------------------------------------------------
// Pushes, reverses, unused codes and rejected commands (pop on empty, push
// on full) do not block the request channel themselves, so such commands can
// transfer every cycle while the output register is free or being drained.
// A pop that returns data blocks the request channel until its registered
// store read has put the word in the output register. Results wait in that
// register until taken; a command transfers only when the output register is
// free or being drained in the same cycle. No clearing pass is needed after
// reset: entries are never read before they are written.
module reversible_deque
   import rvdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rvdq_req_if.sink   req_chan,
   rvdq_rsp_if.source rsp_chan
);

   ctl_type           ctl;
   logic              accept;
   logic [DATA_W-1:0] rdata;

   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   status_type          rsp_status_ff, rsp_status_in;

   assign req_chan.ready = !pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   rvdq_ptr u_ptr (
      .clock   (clock),
      .reset   (reset),
      .go      (accept),
      .command (req_chan.command),
      .ctl     (ctl)
   );

   rvdq_store u_store (
      .clock (clock),
      .wr_en (ctl.wr_en),
      .rd_en (ctl.rd_en),
      .addr  (ctl.addr),
      .wdata (req_chan.value),
      .rdata (rdata)
   );

   always_comb begin
      pend_in       = accept && ctl.rd_en;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rdata;
         rsp_status_in = ST_OK;
      end else if (accept && ctl.rsp_now) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = ctl.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // a pending read must find the output register empty
   a_pend_out_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("pop data arrives while output register is full");

   // a read-back pop becomes an ok result in the next cycle
   a_pend_result: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> (rsp_valid_ff && rsp_status_ff == ST_OK))
      else $error("pending pop did not produce an ok result");

   // no further transfer while a read is in flight
   a_pend_block: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl.rd_en) |=> !req_chan.ready)
      else $error("command accepted during pending store read");

   // a store write and a store read never share a cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_en && ctl.rd_en))
      else $error("store read and write in the same cycle");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for reversible_deque. A queue of commands built up
// front feeds a clocked driver; a clocked monitor compares every pop or
// reject result against a shadow deque updated on each accepted command.
// Both handshake sides draw random wait times, with calm stretches.
// ----------------------------------------------------------------------------
module tb_top;
   import rvdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   localparam logic [CMD_W-1:0] CMD_LAST = '1;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] value;
      bit                hold;    // wait for all results before sending
   } deque_cmd_type;

   typedef struct {
      logic [DATA_W-1:0] data_out;
      status_type        status;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset;

   rvdq_req_if req_if ();
   rvdq_rsp_if rsp_if ();

   reversible_deque uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   deque_cmd_type    cmd_q[$];
   deque_result_type expected_q[$];
   int               mismatch_count = 0;
   int               fill_level = 0;    // occupancy tracked while building stimulus
   int               send_calm = 0;
   int               recv_calm = 0;

   // shadow deque
   logic [DATA_W-1:0] shadow_mem [DEPTH];
   logic [IDX_W-1:0]  shadow_head = '0;
   logic [CNT_W-1:0]  shadow_count = '0;
   logic              shadow_rev = 1'b0;

   function automatic void deque_apply(input logic [CMD_W-1:0] cmd,
                                       input logic [DATA_W-1:0] word);
      deque_result_type res;
      logic             at_front;
      int               slot;
      res.data_out = '0;
      case (cmd)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
               expected_q.insert(expected_q.size(), res);
            end else begin
               at_front = (cmd == CMD_PUSH_FRONT) ^ shadow_rev;
               if (at_front) begin
                  shadow_head = (shadow_head == 0) ? IDX_W'(DEPTH - 1) : shadow_head - 1'b1;
                  shadow_mem[shadow_head] = word;
               end else begin
                  slot = (int'(shadow_head) + int'(shadow_count)) % DEPTH;
                  shadow_mem[slot] = word;
               end
               shadow_count = shadow_count + 1'b1;
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               at_front = (cmd == CMD_POP_FRONT) ^ shadow_rev;
               if (at_front) begin
                  res.data_out = shadow_mem[shadow_head];
                  shadow_head = IDX_W'((int'(shadow_head) + 1) % DEPTH);
               end else begin
                  slot = (int'(shadow_head) + int'(shadow_count) - 1) % DEPTH;
                  res.data_out = shadow_mem[slot];
               end
               shadow_count = shadow_count - 1'b1;
               res.status = ST_OK;
            end
            expected_q.insert(expected_q.size(), res);
         end
         CMD_REVERSE: shadow_rev = ~shadow_rev;
         default: ;   // unused codes change nothing
      endcase
   endfunction

   // wait time for one item; occasional runs of back-to-back items
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 40) == 0)
         calm = $urandom_range(10, 40);
      return $urandom_range(0, 7);
   endfunction

   function automatic void add_cmd(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
                                   input bit hold = 1'b0);
      deque_cmd_type item;
      item.command = c;
      item.value   = v;
      item.hold    = hold;
      cmd_q.insert(cmd_q.size(), item);
      case (c)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: if (fill_level < DEPTH) fill_level++;
         CMD_POP_BACK, CMD_POP_FRONT:   if (fill_level > 0) fill_level--;
         default: ;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct, input int pop_pct,
                                                  input int rev_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      if (r < push_pct + pop_pct)
         return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      if (r < push_pct + pop_pct + rev_pct)
         return CMD_REVERSE;
      return CMD_W'($urandom_range(int'(CMD_REVERSE) + 1, int'(CMD_LAST)));
   endfunction

   function automatic void note_mismatch(input string what, input deque_result_type exp_res);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected data %h status %0d, got data %h status %0d",
                  $realtime, what, exp_res.data_out, exp_res.status,
                  rsp_if.data_out, rsp_if.status);
   endfunction

   // command driver
   int send_wait;

   always @(posedge clock) begin
      deque_cmd_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            deque_apply(req_if.command, req_if.value);
         if (!req_if.valid || req_if.ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_if.valid <= 1'b0;
            end else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].hold && (expected_q.size() > 0 || req_if.valid))) begin
               item = cmd_q.pop_front();
               req_if.command <= item.command;
               req_if.value   <= item.value;
               req_if.valid   <= 1'b1;
               send_wait <= draw_wait(send_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   int recv_wait;

   always @(posedge clock) begin
      deque_result_type exp_res;
      int               n;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            exp_res.data_out = 'x;
            exp_res.status   = ST_OK;
            note_mismatch("result with nothing expected", exp_res);
         end else begin
            exp_res = expected_q.pop_front();
            if (rsp_if.data_out !== exp_res.data_out || rsp_if.status !== exp_res.status)
               note_mismatch("result mismatch", exp_res);
         end
         n = draw_wait(recv_calm);
         recv_wait <= n;
         rsp_if.ready <= (n == 0);
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_if.ready <= (recv_wait == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // run limit
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("reversible_deque regression: fail");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.command = CMD_PUSH_BACK;
      req_if.value   = '0;
      rsp_if.ready   = 1'b0;
      reset = 1'b1;

      // directed: empty pops, extreme words, both orientations, unused codes
      add_cmd(CMD_POP_BACK, 32'h0);
      add_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF);
      add_cmd(CMD_PUSH_BACK, 32'h0000_0000);
      add_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      add_cmd(CMD_PUSH_BACK, 32'hA5A5_A5A5);
      add_cmd(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
      add_cmd(CMD_POP_FRONT, 32'h0);
      add_cmd(CMD_POP_BACK, 32'h0);
      add_cmd(CMD_REVERSE, 32'hFFFF_FFFF);
      add_cmd(CMD_PUSH_BACK, 32'h1234_5678);
      add_cmd(CMD_PUSH_FRONT, 32'h8000_0001);
      add_cmd(CMD_POP_FRONT, 32'h0);
      add_cmd(CMD_POP_BACK, 32'h0);
      add_cmd(CMD_POP_FRONT, 32'h0);
      add_cmd(CMD_POP_BACK, 32'h0);
      add_cmd(CMD_POP_BACK, 32'h0);
      add_cmd(CMD_REVERSE, 32'h0);
      for (int c = int'(CMD_REVERSE) + 1; c <= int'(CMD_LAST); c++)
         add_cmd(CMD_W'(c), $urandom());
      add_cmd(CMD_POP_FRONT, 32'h0);

      // shallow mixed traffic
      for (int i = 0; i < 200; i++)
         add_cmd(pick_cmd(45, 40, 10), $urandom(), i == 0);

      // grow a deep queue, flip it, then drain past empty
      add_cmd(CMD_REVERSE, $urandom(), 1'b1);
      for (int i = 0; i < 260; i++)
         add_cmd(pick_cmd(75, 15, 5), $urandom());
      add_cmd(CMD_REVERSE, $urandom());
      while (fill_level > 0)
         add_cmd(pick_cmd(8, 85, 5), $urandom());
      for (int i = 0; i < 4; i++)
         add_cmd(pick_cmd(0, 100, 0), $urandom());

      for (int i = 0; i < 150; i++)
         add_cmd(pick_cmd(45, 40, 10), $urandom(), i == 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so driver and monitor updates have settled
      while (cmd_q.size() > 0 || req_if.valid || expected_q.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("reversible_deque regression: pass");
      else
         $display("reversible_deque regression: fail");
      $finish;
   end

endmodule
